// ===== hw/rtl/shfa_pkg.sv =====
// Package for the serial HID report frame assembler.
// Frame codes, report kinds and the frame-done struct shared by all modules.
// No dependencies.
package shfa_pkg;

    localparam logic [7:0] MOUSE_START = 8'h4D;  // 'M'
    localparam logic [7:0] KBD_START   = 8'h4B;  // 'K'
    localparam logic [2:0] MOUSE_LEN   = 3'd4;
    localparam logic [2:0] KBD_LEN     = 3'd6;
    localparam int         FRAME_DEPTH = 6;
    localparam int         NUM_KEYS    = 4;

    localparam logic MODE_BYTE = 1'b0;  // received serial byte
    localparam logic MODE_EP   = 1'b1;  // report endpoint ready

    localparam logic KIND_MOUSE = 1'b0;
    localparam logic KIND_KBD   = 1'b1;

    typedef logic [7:0] t_byte;

    // Completed frame, data bytes 1..5 as stored (byte 0 is the start code).
    typedef struct packed {
        logic                          mouse_done;
        logic                          kbd_done;
        logic [FRAME_DEPTH-2:0][7:0]   data;  // data[0] = frame byte 1
    } t_frame_done;

endpackage

// ===== hw/rtl/shfa_frame.sv =====
// Frame collector: byte counter, write index and frame byte store.
// Flags a completed mouse or keyboard frame in the cycle its last byte lands.
// Depends on shfa_pkg.
module shfa_frame
    import shfa_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_take,
    input  t_byte       i_byte,
    output t_frame_done o_done
);

    logic [2:0] r_remaining, n_remaining;
    logic [2:0] r_wr_idx, n_wr_idx;
    t_byte      r_frame [FRAME_DEPTH];

    logic [2:0] rem_start;
    logic       active;
    logic       finish;
    t_byte      merged [FRAME_DEPTH];

    // Remaining count seen by this byte: a start code outside a frame opens one.
    always_comb begin
        rem_start = r_remaining;
        if (r_remaining == 3'd0) begin
            priority if (i_byte == MOUSE_START) begin
                rem_start = MOUSE_LEN;
            end else if (i_byte == KBD_START) begin
                rem_start = KBD_LEN;
            end
        end
    end

    assign active = i_take && (rem_start != 3'd0);
    assign finish = active && (rem_start == 3'd1);

    // Frame contents as they stand once the current byte is written.
    always_comb begin
        for (int i = 0; i < FRAME_DEPTH; i++) begin
            merged[i] = (r_wr_idx == 3'(i)) ? i_byte : r_frame[i];
        end
    end

    always_comb begin
        n_remaining = r_remaining;
        n_wr_idx    = r_wr_idx;
        if (active) begin
            n_remaining = rem_start - 3'd1;
            n_wr_idx    = finish ? 3'd0 : r_wr_idx + 3'd1;
        end
    end

    always_comb begin
        o_done.mouse_done = finish && (merged[0] == MOUSE_START);
        o_done.kbd_done   = finish && (merged[0] == KBD_START);
        for (int i = 0; i < FRAME_DEPTH - 1; i++) begin
            o_done.data[i] = merged[i+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_remaining <= 3'd0;
            r_wr_idx    <= 3'd0;
        end else begin
            r_remaining <= n_remaining;
            r_wr_idx    <= n_wr_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (active && (r_wr_idx < 3'(FRAME_DEPTH))) begin
            r_frame[r_wr_idx] <= i_byte;
        end
    end

endmodule

// ===== hw/rtl/shfa_report.sv =====
// Report state (pending mouse and keyboard reports) and the result register.
// Folds completed frames in; emits at most one pending report per endpoint-ready event.
// Depends on shfa_pkg.
module shfa_report
    import shfa_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_frame_done i_done,
    input  logic        i_fire,
    input  logic        i_out_ready,
    output logic        o_out_valid,
    output logic        o_kind,
    output t_byte       o_buttons,
    output t_byte       o_dx,
    output t_byte       o_dy,
    output t_byte       o_modifiers,
    output t_byte       o_key0,
    output t_byte       o_key1,
    output t_byte       o_key2,
    output t_byte       o_key3
);

    t_byte r_buttons, n_buttons;
    t_byte r_dx, n_dx;
    t_byte r_dy, n_dy;
    t_byte r_mods, n_mods;
    t_byte r_keys [NUM_KEYS];
    t_byte n_keys [NUM_KEYS];
    logic  r_mouse_pend, n_mouse_pend;
    logic  r_kbd_pend, n_kbd_pend;

    logic  r_out_valid, n_out_valid;
    logic  r_kind, n_kind;
    t_byte r_o_buttons, n_o_buttons;
    t_byte r_o_dx, n_o_dx;
    t_byte r_o_dy, n_o_dy;
    t_byte r_o_mods, n_o_mods;
    t_byte r_o_keys [NUM_KEYS];
    t_byte n_o_keys [NUM_KEYS];

    always_comb begin
        n_buttons    = r_buttons;
        n_dx         = r_dx;
        n_dy         = r_dy;
        n_mods       = r_mods;
        n_keys       = r_keys;
        n_mouse_pend = r_mouse_pend;
        n_kbd_pend   = r_kbd_pend;

        n_out_valid  = r_out_valid && !i_out_ready;
        n_kind       = r_kind;
        n_o_buttons  = r_o_buttons;
        n_o_dx       = r_o_dx;
        n_o_dy       = r_o_dy;
        n_o_mods     = r_o_mods;
        n_o_keys     = r_o_keys;

        if (i_done.mouse_done) begin
            n_buttons    = i_done.data[0];
            n_dx         = r_dx + i_done.data[1];  // wraps mod 256
            n_dy         = r_dy + i_done.data[2];
            n_mouse_pend = 1'b1;
        end
        if (i_done.kbd_done) begin
            n_mods     = i_done.data[0];
            for (int i = 0; i < NUM_KEYS; i++) begin
                n_keys[i] = i_done.data[i+1];
            end
            n_kbd_pend = 1'b1;
        end

        // Mouse report wins over keyboard.
        if (i_fire) begin
            priority if (r_mouse_pend) begin
                n_out_valid  = 1'b1;
                n_kind       = KIND_MOUSE;
                n_o_buttons  = r_buttons;
                n_o_dx       = r_dx;
                n_o_dy       = r_dy;
                n_o_mods     = 8'd0;
                for (int i = 0; i < NUM_KEYS; i++) begin
                    n_o_keys[i] = 8'd0;
                end
                n_buttons    = 8'd0;
                n_dx         = 8'd0;
                n_dy         = 8'd0;
                n_mouse_pend = 1'b0;
            end else if (r_kbd_pend) begin
                n_out_valid = 1'b1;
                n_kind      = KIND_KBD;
                n_o_buttons = 8'd0;
                n_o_dx      = 8'd0;
                n_o_dy      = 8'd0;
                n_o_mods    = r_mods;
                n_o_keys    = r_keys;
                n_keys[0]   = 8'd0;
                n_kbd_pend  = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buttons    <= 8'd0;
            r_dx         <= 8'd0;
            r_dy         <= 8'd0;
            r_mods       <= 8'd0;
            for (int i = 0; i < NUM_KEYS; i++) begin
                r_keys[i] <= 8'd0;
            end
            r_mouse_pend <= 1'b0;
            r_kbd_pend   <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_buttons    <= n_buttons;
            r_dx         <= n_dx;
            r_dy         <= n_dy;
            r_mods       <= n_mods;
            r_keys       <= n_keys;
            r_mouse_pend <= n_mouse_pend;
            r_kbd_pend   <= n_kbd_pend;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind      <= n_kind;
        r_o_buttons <= n_o_buttons;
        r_o_dx      <= n_o_dx;
        r_o_dy      <= n_o_dy;
        r_o_mods    <= n_o_mods;
        r_o_keys    <= n_o_keys;
    end

    assign o_out_valid = r_out_valid;
    assign o_kind      = r_kind;
    assign o_buttons   = r_o_buttons;
    assign o_dx        = r_o_dx;
    assign o_dy        = r_o_dy;
    assign o_modifiers = r_o_mods;
    assign o_key0      = r_o_keys[0];
    assign o_key1      = r_o_keys[1];
    assign o_key2      = r_o_keys[2];
    assign o_key3      = r_o_keys[3];

    a_mouse_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && r_mouse_pend |=>
            r_out_valid && (r_kind == KIND_MOUSE) && !r_mouse_pend
            && (r_dx == 8'd0) && (r_dy == 8'd0))
        else $error("mouse report not issued or not cleared");

    a_kbd_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && !r_mouse_pend && r_kbd_pend |=>
            r_out_valid && (r_kind == KIND_KBD) && !r_kbd_pend
            && (r_keys[0] == 8'd0))
        else $error("keyboard report not issued or key0 not cleared");

    a_kbd_no_mouse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_kind == KIND_KBD) |->
            (r_o_buttons == 8'd0) && (r_o_dx == 8'd0) && (r_o_dy == 8'd0))
        else $error("keyboard report carries mouse data");

endmodule

// ===== hw/rtl/serial_hid_report_frame_assembler_core.sv =====
// Top level of the serial HID report frame assembler.
// Input register, then shfa_frame and shfa_report; depends on shfa_pkg.
//
//   channel | signals                          | direction
//   --------+----------------------------------+----------
//   in      | i_valid/o_ready, i_mode, i_rx_byte | sink
//   out     | o_valid/i_ready, o_report_kind .. o_key_code3 | source
//
// One item per cycle while no endpoint-ready item is held (see below): an accepted
// item is registered in the input register and from there folded into the frame and
// report state, on the same edge at which a report lands in the result register.
// Serial bytes never wait on the output side; an endpoint-ready item waits in
// the input register only while a report is held by a low i_ready.
// Synchronous active-low reset clears counters, pending flags and valids.
module serial_hid_report_frame_assembler_core
    import shfa_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic              i_mode,
    input  logic [7:0]        i_rx_byte,
    output logic              o_valid,
    input  logic              i_ready,
    output logic              o_report_kind,
    output logic [7:0]        o_button_mask,
    output logic signed [7:0] o_delta_x,
    output logic signed [7:0] o_delta_y,
    output logic [7:0]        o_modifier_bits,
    output logic [7:0]        o_key_code0,
    output logic [7:0]        o_key_code1,
    output logic [7:0]        o_key_code2,
    output logic [7:0]        o_key_code3
);

    logic        r_in_valid, n_in_valid;
    logic        r_mode;
    t_byte       r_byte;
    logic        advance;
    t_frame_done done;
    t_byte       dx_u;
    t_byte       dy_u;

    // Bytes always advance; a ready event needs room in the result register.
    assign advance = r_in_valid && ((r_mode == MODE_BYTE) || !o_valid || i_ready);
    assign o_ready = !r_in_valid || advance;

    always_comb begin
        n_in_valid = r_in_valid;
        if (i_valid && o_ready) begin
            n_in_valid = 1'b1;
        end else if (advance) begin
            n_in_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_mode <= i_mode;
            r_byte <= i_rx_byte;
        end
    end

    shfa_frame u_frame (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (advance && (r_mode == MODE_BYTE)),
        .i_byte  (r_byte),
        .o_done  (done)
    );

    shfa_report u_report (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_done      (done),
        .i_fire      (advance && (r_mode == MODE_EP)),
        .i_out_ready (i_ready),
        .o_out_valid (o_valid),
        .o_kind      (o_report_kind),
        .o_buttons   (o_button_mask),
        .o_dx        (dx_u),
        .o_dy        (dy_u),
        .o_modifiers (o_modifier_bits),
        .o_key0      (o_key_code0),
        .o_key1      (o_key_code1),
        .o_key2      (o_key_code2),
        .o_key3      (o_key_code3)
    );

    assign o_delta_x = $signed(dx_u);
    assign o_delta_y = $signed(dy_u);

endmodule
